@@ hw/rtl/tlb_pkg.sv @@
// ----------------------------------------------------------------------------
// tlb_pkg: shared types and constants of the tour lower-bound engine
// Field widths, command codes, the cost-table entry layout and the result
// bundle of the two-cheapest-road tracker.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int COST_W  = 32;
  localparam int BOUND_W = 50;
  localparam int CITY_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  localparam logic signed [BOUND_W-1:0] BOUND_MAX = {1'b0, {(BOUND_W-1){1'b1}}};
  localparam logic signed [BOUND_W-1:0] BOUND_MIN = {1'b1, {(BOUND_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_INITIAL = 2'd1,
    CMD_EXTEND  = 2'd2
  } cmd_e;

  // One cost-table entry: present mark and Q24.8 cost.
  typedef struct packed {
    logic              present;
    logic [COST_W-1:0] cost;
  } entry_t;

  // Roads seen so far (saturates at two) and the two cheapest of them.
  typedef struct packed {
    logic [1:0]        count;
    logic [COST_W-1:0] min1;
    logic [COST_W-1:0] min2;
  } two_min_t;

endpackage

@@ hw/rtl/tlb_ram.sv @@
// ----------------------------------------------------------------------------
// tlb_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module tlb_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hw/rtl/tlb_two_min.sv @@
// ----------------------------------------------------------------------------
// tlb_two_min: two-cheapest-road tracker
// Takes one road cost per enabled cycle and keeps the two cheapest seen since
// the last restart, plus a count of roads seen (saturating at two).
// ----------------------------------------------------------------------------
module tlb_two_min (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic                       en_i,
  input  logic [tlb_pkg::COST_W-1:0] cost_i,
  output tlb_pkg::two_min_t          res_o
);

  tlb_pkg::two_min_t res_q;
  tlb_pkg::two_min_t res_d;
  tlb_pkg::two_min_t base;

  always_comb begin
    // restart folds into this cycle's update, so a fresh walk can begin at once
    base  = restart_i ? '0 : res_q;
    res_d = base;
    if (en_i) begin
      if (base.count == 2'd0) begin
        res_d.min1  = cost_i;
        res_d.count = 2'd1;
      end else if (cost_i < base.min1) begin
        res_d.min2  = base.min1;
        res_d.min1  = cost_i;
        res_d.count = 2'd2;
      end else if (base.count == 2'd1 || cost_i < base.min2) begin
        res_d.min2  = cost_i;
        res_d.count = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ hw/rtl/tour_lower_bound_engine.sv @@
// ----------------------------------------------------------------------------
// tour_lower_bound_engine: two-cheapest-road lower bound for tour search
// Holds a road cost table in RAM and answers write, initial-bound and
// extended-bound commands, one result beat per command beat.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one command beat; output
//   channel (out_valid_o / out_stall_i) returns exactly one result beat for it.
//   cfg_we_i / cfg_wdata_i set city_count; write it only while the block idles.
//   Commands are worked one at a time; the next beat is taken as soon as the
//   current one has left its result in the output register.
//   With n = min(city_count, MAX_CITIES), write and unused codes go straight to
//   the result; an extended bound walks n entries of two columns together, one
//   entry per cycle on each RAM read port; an initial bound walks the whole
//   n-by-n table, one entry a cycle.
//   The rate is set by the single read per cycle on each RAM port.
//   After reset all MAX_CITIES*MAX_CITIES table entries are swept to "no road",
//   with in_stall_o high throughout; configuration writes are still taken.
//   A stalled output register holds its beat; a finished result then waits in
//   the block and no new beat is taken until the register frees.
// ----------------------------------------------------------------------------
module tour_lower_bound_engine #(
  parameter int MAX_CITIES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [tlb_pkg::COUNT_W-1:0]         cfg_wdata_i,
  // command beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [tlb_pkg::CITY_W-1:0]          row_city_i,
  input  logic [tlb_pkg::CITY_W-1:0]          col_city_i,
  input  logic [tlb_pkg::COST_W-1:0]          road_cost_i,
  input  logic                                road_present_i,
  input  logic signed [tlb_pkg::BOUND_W-1:0]  parent_bound_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tlb_pkg::BOUND_W-1:0]  bound_o,
  output logic                                bound_infinite_o,
  output logic [tlb_pkg::COST_W-1:0]          edge_cost_o,
  output logic                                edge_present_o
);

  localparam int IW    = $clog2(MAX_CITIES);
  localparam int CW    = $clog2(MAX_CITIES + 1);
  localparam int DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int AB_W  = tlb_pkg::COST_W + 1;
  localparam int VW    = tlb_pkg::BOUND_W + 2;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ROWS  = 8'b0000_0100,
    S_EDGE  = 8'b0000_1000,
    S_COLS  = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_CALC  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  // Tags that travel alongside a RAM read until its data returns.
  typedef struct packed {
    logic valid;
    logic is_edge;
    logic self_a;
    logic self_b;
    logic first;
    logic last;
    logic fin;
  } tag_t;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    addr_of = AW'(r) * AW'(MAX_CITIES) + AW'(c);
  endfunction

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_e                          state_q, state_d;
  logic [AW-1:0]                   clr_q, clr_d;
  logic [IW-1:0]                   r_q, r_d;
  logic [IW-1:0]                   j_q, j_d;
  logic [tlb_pkg::COUNT_W-1:0]     city_count_q;
  tag_t                            iss, p1_q;
  logic                            p2_last_q, p2_final_q;
  logic                            out_valid_q;

  // Latched command beat
  logic [1:0]                          cmd_q;
  logic [tlb_pkg::CITY_W-1:0]          row_q, col_q;
  logic signed [tlb_pkg::BOUND_W-1:0]  parent_q;
  logic [CW-1:0]                       n_q;
  logic                                row_ok_q, col_ok_q;

  // Working values
  logic [tlb_pkg::BOUND_W-1:0]         sum_q, sum_d;
  logic                                inf_q, inf_d;
  logic                                have_q;
  logic [tlb_pkg::COST_W-1:0]          ecost_q;
  logic [AB_W-1:0]                     ab_q, ab_d;
  logic                                ext_inf_q, ext_inf_d;

  // Result waiting for the output register, and the output register itself
  logic signed [tlb_pkg::BOUND_W-1:0]  res_bound_q, res_bound_d;
  logic                                res_inf_q, res_inf_d;
  logic [tlb_pkg::COST_W-1:0]          res_ecost_q, res_ecost_d;
  logic                                res_epres_q, res_epres_d;
  logic signed [tlb_pkg::BOUND_W-1:0]  bound_q;
  logic                                bound_inf_q;
  logic [tlb_pkg::COST_W-1:0]          ecost_out_q;
  logic                                epres_out_q;

  logic                                accept;
  logic                                out_load;
  logic [CW-1:0]                       n_eff;
  logic [CW-1:0]                       n_last;
  logic                                j_last, r_last;
  logic                                in_row_ok, in_col_ok;
  logic [IW-1:0]                       row_idx, col_idx;

  logic                                ram_we;
  logic [AW-1:0]                       ram_waddr;
  tlb_pkg::entry_t                     ram_wdata;
  logic [AW-1:0]                       addr_a, addr_b;
  tlb_pkg::entry_t                     rd_a, rd_b;

  logic                                tm_restart;
  logic                                tm_a_en, tm_b_en;
  tlb_pkg::two_min_t                   tm_a, tm_b;

  logic [tlb_pkg::COST_W-1:0]          a_sel, b_sel;
  logic signed [VW-1:0]                v;
  logic signed [tlb_pkg::BOUND_W-1:0]  v_sat;

  // --------------------------------------------------------------------------
  // Handshake and small decodes
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // counts above the table size act as the table size
  assign n_eff  = (32'(city_count_q) > MAX_CITIES) ? CW'(MAX_CITIES) : CW'(city_count_q);
  assign n_last = n_q - CW'(1);
  assign j_last = (CW'(j_q) == n_last);
  assign r_last = (CW'(r_q) == n_last);

  assign in_row_ok = (32'(row_city_i) < MAX_CITIES);
  assign in_col_ok = (32'(col_city_i) < MAX_CITIES);
  assign row_idx   = IW'(row_q);
  assign col_idx   = IW'(col_q);

  // --------------------------------------------------------------------------
  // Cost table
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(IW'(row_city_i), IW'(col_city_i));
    ram_wdata = '0;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
    end else if (accept && command_i == tlb_pkg::CMD_WRITE && in_row_ok && in_col_ok) begin
      ram_we = 1'b1;
      // an absent road stores cost zero
      if (road_present_i) begin
        ram_wdata.present = 1'b1;
        ram_wdata.cost    = road_cost_i;
      end
    end
  end

  always_comb begin
    case (state_q)
      S_ROWS:  addr_a = addr_of(r_q, j_q);
      S_EDGE:  addr_a = addr_of(row_idx, col_idx);
      default: addr_a = addr_of(j_q, row_idx);
    endcase
    addr_b = addr_of(j_q, col_idx);
  end

  tlb_ram #(
    .WIDTH ($bits(tlb_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (addr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (addr_b),
    .rdata_b_o (rd_b)
  );

  // --------------------------------------------------------------------------
  // Two-cheapest trackers: A walks rows (initial) or the current city's
  // column (extended); B walks the next city's column.
  // --------------------------------------------------------------------------
  assign tm_restart = (accept && command_i == tlb_pkg::CMD_EXTEND) ||
                      (p1_q.valid && p1_q.first);
  assign tm_a_en = p1_q.valid && !p1_q.is_edge && rd_a.present && !p1_q.self_a &&
                   (cmd_q == tlb_pkg::CMD_INITIAL || row_ok_q);
  assign tm_b_en = p1_q.valid && !p1_q.is_edge && rd_b.present && !p1_q.self_b &&
                   cmd_q == tlb_pkg::CMD_EXTEND && col_ok_q;

  tlb_two_min u_min_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (tm_restart),
    .en_i      (tm_a_en),
    .cost_i    (rd_a.cost),
    .res_o     (tm_a)
  );

  tlb_two_min u_min_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (tm_restart),
    .en_i      (tm_b_en),
    .cost_i    (rd_b.cost),
    .res_o     (tm_b)
  );

  // --------------------------------------------------------------------------
  // Row accumulation for the initial bound; a row's pair is final in the cycle
  // after its last entry returned. Half of a Q.8 sum at 9 fraction bits is
  // the sum itself, so no shift.
  // --------------------------------------------------------------------------
  always_comb begin
    sum_d = sum_q;
    inf_d = inf_q;
    if (accept) begin
      sum_d = '0;
      inf_d = 1'b0;
    end else if (p2_last_q && cmd_q == tlb_pkg::CMD_INITIAL) begin
      sum_d = sum_q + tlb_pkg::BOUND_W'(tm_a.min1) + tlb_pkg::BOUND_W'(tm_a.min2);
      inf_d = inf_q | (tm_a.count < 2'd2);
    end
  end

  // --------------------------------------------------------------------------
  // Extended bound arithmetic: pick the road that pairs with the step road,
  // then parent + 2c - (a + b), saturated to the bound range.
  // --------------------------------------------------------------------------
  assign a_sel     = (ecost_q >= tm_a.min2) ? tm_a.min2 : tm_a.min1;
  assign b_sel     = (ecost_q >= tm_b.min2) ? tm_b.min2 : tm_b.min1;
  assign ab_d      = AB_W'(a_sel) + AB_W'(b_sel);
  assign ext_inf_d = !have_q || (tm_a.count < 2'd2) || (tm_b.count < 2'd2);

  always_comb begin
    v = VW'(parent_q) + $signed(VW'({ecost_q, 1'b0})) - $signed(VW'(ab_q));
    if (v > tlb_pkg::BOUND_MAX) begin
      v_sat = tlb_pkg::BOUND_MAX;
    end else if (v < tlb_pkg::BOUND_MIN) begin
      v_sat = tlb_pkg::BOUND_MIN;
    end else begin
      v_sat = tlb_pkg::BOUND_W'(v);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    r_d         = r_q;
    j_d         = j_q;
    iss         = '0;
    res_bound_d = res_bound_q;
    res_inf_d   = res_inf_q;
    res_ecost_d = res_ecost_q;
    res_epres_d = res_epres_q;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          r_d         = '0;
          j_d         = '0;
          res_bound_d = '0;
          res_inf_d   = 1'b0;
          res_ecost_d = '0;
          res_epres_d = 1'b0;
          case (command_i)
            tlb_pkg::CMD_INITIAL: begin
              // no cities in use: bound zero, straight to the result
              state_d = (n_eff == '0) ? S_DONE : S_ROWS;
            end
            tlb_pkg::CMD_EXTEND: state_d = S_EDGE;
            default:             state_d = S_DONE;
          endcase
        end
      end

      S_ROWS: begin
        iss.valid  = 1'b1;
        iss.self_a = (r_q == j_q);
        iss.first  = (j_q == '0);
        iss.last   = j_last;
        iss.fin    = j_last && r_last;
        j_d        = j_q + IW'(1);
        if (j_last) begin
          j_d = '0;
          r_d = r_q + IW'(1);
          if (r_last) begin
            state_d = S_WAIT;
          end
        end
      end

      S_EDGE: begin
        iss.valid   = 1'b1;
        iss.is_edge = 1'b1;
        iss.fin     = (n_q == '0);
        iss.last    = (n_q == '0);
        state_d     = (n_q == '0) ? S_WAIT : S_COLS;
      end

      S_COLS: begin
        iss.valid  = 1'b1;
        iss.self_a = (32'(j_q) == 32'(row_q));
        iss.self_b = (32'(j_q) == 32'(col_q));
        iss.last   = j_last;
        iss.fin    = j_last;
        j_d        = j_q + IW'(1);
        if (j_last) begin
          state_d = S_WAIT;
        end
      end

      S_WAIT: begin
        if (p2_final_q) begin
          if (cmd_q == tlb_pkg::CMD_INITIAL) begin
            res_bound_d = inf_d ? tlb_pkg::BOUND_MAX : $signed(sum_d);
            res_inf_d   = inf_d;
            state_d     = S_DONE;
          end else begin
            state_d = S_CALC;
          end
        end
      end

      S_CALC: begin
        res_bound_d = ext_inf_q ? tlb_pkg::BOUND_MAX : v_sat;
        res_inf_d   = ext_inf_q;
        res_ecost_d = ecost_q;
        res_epres_d = have_q;
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      r_q          <= '0;
      j_q          <= '0;
      city_count_q <= tlb_pkg::COUNT_RESET;
      p1_q         <= '0;
      p2_last_q    <= 1'b0;
      p2_final_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      cmd_q        <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      r_q        <= r_d;
      j_q        <= j_d;
      p1_q       <= iss;
      p2_last_q  <= p1_q.valid && p1_q.last;
      p2_final_q <= p1_q.valid && p1_q.fin;
      if (cfg_we_i) begin
        city_count_q <= cfg_wdata_i;
      end
      if (accept) begin
        cmd_q <= command_i;
      end
      // hold a stalled beat, drop it once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q    <= row_city_i;
      col_q    <= col_city_i;
      parent_q <= parent_bound_i;
      n_q      <= n_eff;
      row_ok_q <= in_row_ok;
      col_ok_q <= in_col_ok;
    end
    sum_q <= sum_d;
    inf_q <= inf_d;
    // capture the step road as it returns
    if (p1_q.valid && p1_q.is_edge) begin
      have_q  <= row_ok_q && col_ok_q && (row_q != col_q) && rd_a.present;
      ecost_q <= (row_ok_q && col_ok_q && (row_q != col_q) && rd_a.present) ?
                 rd_a.cost : '0;
    end
    if (state_q == S_WAIT) begin
      ab_q      <= ab_d;
      ext_inf_q <= ext_inf_d;
    end
    res_bound_q <= res_bound_d;
    res_inf_q   <= res_inf_d;
    res_ecost_q <= res_ecost_d;
    res_epres_q <= res_epres_d;
    if (out_load) begin
      bound_q     <= res_bound_q;
      bound_inf_q <= res_inf_q;
      ecost_out_q <= res_ecost_q;
      epres_out_q <= res_epres_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bound_o          = bound_q;
  assign bound_infinite_o = bound_inf_q;
  assign edge_cost_o      = ecost_out_q;
  assign edge_present_o   = epres_out_q;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tour lower-bound engine
// Drives command beats (road writes, initial bounds, extended bounds and the
// spare code) under phases of sender idling and receiver stalling, keeps a
// private road table and city count to predict every result beat, and checks
// each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlb_pkg::*;

  localparam int N_CITIES     = 64;
  localparam int ITEM_TARGET  = 850;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int TAIL_CYCLES  = 200;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES  = 300;

  // Spare command code: the block must leave the table alone and return zeros.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam longint SAT_HI = (longint'(1) <<< (BOUND_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (BOUND_W - 1));

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idling_e;

  // One command beat as offered on the input channel.
  typedef struct packed {
    logic [1:0]         command;
    logic [CITY_W-1:0]  row_city;
    logic [CITY_W-1:0]  col_city;
    logic [COST_W-1:0]  road_cost;
    logic               road_present;
    logic [BOUND_W-1:0] parent_bound;
  } beat_t;

  localparam int BEAT_W = $bits(beat_t);

  // One result beat as returned on the output channel.
  typedef struct packed {
    logic [BOUND_W-1:0] bound;
    logic               infinite;
    logic [COST_W-1:0]  edge_cost;
    logic               edge_present;
  } result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = '0;
  logic [CITY_W-1:0]  in_row     = '0;
  logic [CITY_W-1:0]  in_col     = '0;
  logic [COST_W-1:0]  in_cost    = '0;
  logic               in_present = 1'b0;
  logic [BOUND_W-1:0] in_parent  = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [BOUND_W-1:0] res_bound;
  logic                      res_infinite;
  logic [COST_W-1:0]         res_edge_cost;
  logic                      res_edge_present;

  always #5 clk = ~clk;

  tour_lower_bound_engine #(
    .MAX_CITIES(N_CITIES)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (in_command),
    .row_city_i      (in_row),
    .col_city_i      (in_col),
    .road_cost_i     (in_cost),
    .road_present_i  (in_present),
    .parent_bound_i  (in_parent),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .bound_o         (res_bound),
    .bound_infinite_o(res_infinite),
    .edge_cost_o     (res_edge_cost),
    .edge_present_o  (res_edge_present)
  );

  // --------------------------------------------------------------------------
  // Bench state: predicted road table, city count and pending results
  // --------------------------------------------------------------------------
  entry_t             road_tab [N_CITIES*N_CITIES];
  logic [COUNT_W-1:0] cities_cfg;
  result_t            pending_q [$];

  int unsigned beats_sent     = 0;
  int unsigned fault_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Long receiver hold-off: the test bumps hold_go, the stall process counts.
  int unsigned hold_len  = 0;
  int unsigned hold_go   = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // --------------------------------------------------------------------------
  // Bound predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned active_cities();
    return (cities_cfg > N_CITIES) ? N_CITIES : cities_cfg;
  endfunction

  // Road src -> dst; self-roads and absent entries do not count.
  function automatic logic road_between(input int unsigned src, input int unsigned dst,
                                        output logic [COST_W-1:0] cost);
    entry_t e;
    cost = '0;
    if (src >= N_CITIES || dst >= N_CITIES || src == dst) return 1'b0;
    e = road_tab[src*N_CITIES + dst];
    if (!e.present) return 1'b0;
    cost = e.cost;
    return 1'b1;
  endfunction

  // Walk a row (roads out of city) or a column (roads into city) over the
  // cities in use; keep the two cheapest, return how many were seen (max 2).
  function automatic int cheapest_pair(input int unsigned city, input bit along_row,
                                       output logic [COST_W-1:0] lo,
                                       output logic [COST_W-1:0] hi);
    int                seen;
    int unsigned       span;
    logic              ok;
    logic [COST_W-1:0] c;
    lo   = '0;
    hi   = '0;
    seen = 0;
    span = active_cities();
    for (int unsigned i = 0; i < span; i++) begin
      if (along_row) ok = road_between(city, i, c);
      else ok = road_between(i, city, c);
      if (!ok) continue;
      if (seen == 0) begin
        lo   = c;
        seen = 1;
      end else if (c < lo) begin
        hi   = lo;
        lo   = c;
        seen = 2;
      end else if (seen == 1 || c < hi) begin
        hi   = c;
        seen = 2;
      end
    end
    return seen;
  endfunction

  // Work out the result of one accepted beat; writes update the table.
  function automatic result_t bound_for_beat(input beat_t b);
    result_t           r;
    logic [COST_W-1:0] c, lo, hi, a_lo, a_hi, b_lo, b_hi, into_cur, into_next;
    longint unsigned   sum;
    longint            v;
    logic              have;
    int                ka, kb;
    int unsigned       span;
    r = '0;
    case (b.command)
      CMD_WRITE: begin
        road_tab[int'(b.row_city)*N_CITIES + int'(b.col_city)] =
          b.road_present ? entry_t'({1'b1, b.road_cost}) : entry_t'('0);
      end
      CMD_INITIAL: begin
        sum  = 0;
        span = active_cities();
        for (int unsigned i = 0; i < span; i++) begin
          if (cheapest_pair(i, 1'b1, lo, hi) < 2) r.infinite = 1'b1;
          sum += longint'(lo) + longint'(hi);
        end
        // halving a Q.8 sum into 9 fraction bits leaves the raw sum unchanged
        r.bound = r.infinite ? BOUND_MAX : sum[BOUND_W-1:0];
      end
      CMD_EXTEND: begin
        have = road_between(b.row_city, b.col_city, c);
        ka   = cheapest_pair(b.row_city, 1'b0, a_lo, a_hi);
        kb   = cheapest_pair(b.col_city, 1'b0, b_lo, b_hi);
        r.edge_cost    = c;
        r.edge_present = have;
        if (!have || ka < 2 || kb < 2) begin
          r.infinite = 1'b1;
          r.bound    = BOUND_MAX;
        end else begin
          into_cur  = (c >= a_hi) ? a_hi : a_lo;
          into_next = (c >= b_hi) ? b_hi : b_lo;
          v = longint'($signed(b.parent_bound)) + 2 * longint'(c)
              - longint'(into_cur) - longint'(into_next);
          if (v > SAT_HI) v = SAT_HI;
          else if (v < SAT_LO) v = SAT_LO;
          r.bound = v[BOUND_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return COST_W'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [BOUND_W-1:0] pick_parent();
    case ($urandom_range(9))
      0:       return BOUND_MAX;
      1:       return BOUND_MIN;
      2, 3:    return BOUND_W'({$urandom, $urandom});
      default: return BOUND_W'($signed({$urandom, $urandom}) >>> 26);
    endcase
  endfunction

  // Fill every field at random; callers overwrite the ones that matter.
  function automatic beat_t random_beat();
    return BEAT_W'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  task automatic set_idling(input idling_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 46; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default:       begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  // Write city_count; only ever called with the block idle.
  task automatic set_city_count(input logic [COUNT_W-1:0] n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cities_cfg  = n;
  endtask

  // Offer one beat, hold it until taken, then log its predicted result.
  task automatic send_beat(input beat_t b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= b.command;
    in_row     <= b.row_city;
    in_col     <= b.col_city;
    in_cost    <= b.road_cost;
    in_present <= b.road_present;
    in_parent  <= b.parent_bound;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(bound_for_beat(b));
    beats_sent++;
  endtask

  task automatic send_road(input int unsigned row, input int unsigned col,
                           input logic [COST_W-1:0] cost, input logic present);
    beat_t b;
    b              = random_beat();
    b.command      = CMD_WRITE;
    b.row_city     = CITY_W'(row);
    b.col_city     = CITY_W'(col);
    b.road_cost    = cost;
    b.road_present = present;
    send_beat(b);
  endtask

  task automatic ask_initial();
    beat_t b;
    b         = random_beat();
    b.command = CMD_INITIAL;
    send_beat(b);
  endtask

  task automatic ask_extend(input int unsigned row, input int unsigned col,
                            input logic [BOUND_W-1:0] parent);
    beat_t b;
    b              = random_beat();
    b.command      = CMD_EXTEND;
    b.row_city     = CITY_W'(row);
    b.col_city     = CITY_W'(col);
    b.parent_bound = parent;
    send_beat(b);
  endtask

  task automatic send_spare_code();
    beat_t b;
    b         = random_beat();
    b.command = CMD_SPARE;
    send_beat(b);
  endtask

  // Drop valid and wait until every predicted result has been returned.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight after reset: table swept to no road, city count 64.
  task automatic test_after_reset();
    set_idling(IDLE_NONE);
    ask_initial();
    ask_extend(0, 1, '0);
    send_spare_code();
    wait_idle();
  endtask

  // Hand-built three-city table: self-roads, absent roads, spare code and
  // saturation at both ends of the bound range.
  task automatic test_directed();
    set_idling(IDLE_NONE);
    set_city_count(7'd3);
    send_road(0, 1, '0, 1'b1);
    send_road(0, 2, '1, 1'b1);
    send_road(1, 0, 32'd5, 1'b1);
    send_road(1, 2, 32'd7, 1'b1);
    send_road(2, 0, 32'd3, 1'b1);
    send_road(2, 1, 32'h100, 1'b1);
    send_road(1, 1, 32'd9, 1'b1);       // self-road: stored but never counted
    ask_initial();
    ask_extend(0, 1, '0);
    ask_extend(2, 2, '0);               // step onto the same city
    send_road(1, 2, 32'hdead, 1'b0);    // no-road write must store cost zero
    ask_extend(1, 2, '0);
    ask_initial();                      // row 1 is left with a single road
    send_spare_code();
    // expensive step from a cheap column: push past the top of the range
    send_road(0, 1, '1, 1'b1);
    send_road(1, 0, 32'd1, 1'b1);
    send_road(2, 0, 32'd1, 1'b1);
    send_road(2, 1, 32'd1, 1'b1);
    ask_extend(0, 1, BOUND_MAX);
    // free step into a dear column: drive below the bottom of the range
    send_road(0, 1, '0, 1'b1);
    send_road(1, 0, '1, 1'b1);
    send_road(2, 0, '1, 1'b1);
    ask_extend(0, 1, BOUND_MIN);
    wait_idle();
  endtask

  // City counts at and beyond the edges of their range.
  task automatic test_count_extremes();
    set_idling(IDLE_RECEIVER);
    set_city_count('0);
    ask_initial();                      // no cities: bound zero, finite
    wait_idle();
    set_city_count(7'd1);
    ask_initial();
    ask_extend(0, 1, pick_parent());
    wait_idle();
    set_city_count(7'd2);
    ask_initial();
    ask_extend(1, 0, pick_parent());
    wait_idle();
    set_city_count(7'd65);              // clamps to the table size
    ask_extend(0, 1, pick_parent());
    ask_extend(63, 62, pick_parent());
    wait_idle();
  endtask

  // Whole table in use: a ring gives every city two roads out and two in.
  task automatic test_full_table();
    int unsigned row, hop;
    set_idling(IDLE_BOTH);
    set_city_count(COUNT_W'(N_CITIES));
    for (int unsigned i = 0; i < N_CITIES; i++) begin
      send_road(i, (i + 1) % N_CITIES, pick_cost(), 1'b1);
      send_road(i, (i + 3) % N_CITIES, pick_cost(), 1'b1);
    end
    ask_initial();
    repeat (20) begin
      row = $urandom_range(N_CITIES - 1);
      hop = ($urandom_range(1) != 0) ? 1 : 3;
      ask_extend(row, (row + hop) % N_CITIES, pick_parent());
    end
    repeat (4) ask_extend($urandom_range(63), $urandom_range(63), pick_parent());
    wait_idle();
    set_city_count('1);
    ask_initial();
    send_road(0, 1, pick_cost(), 1'b0); // break the ring
    ask_extend(0, 1, pick_parent());
    ask_initial();
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the output register and the finished result back up into the input.
  task automatic test_output_hold();
    set_idling(IDLE_NONE);
    set_city_count(7'd5);
    hold_len = HOLD_CYCLES;
    hold_go++;
    repeat (8) begin
      send_road($urandom_range(4), $urandom_range(4), pick_cost(), 1'b1);
      ask_extend($urandom_range(4), $urandom_range(4), pick_parent());
    end
    wait_idle();
  endtask

  // Phases of random traffic: fill the corner of the table that is in use,
  // then mix steps, rewrites, knock-outs, stray writes and the spare code.
  task automatic test_random_traffic();
    int unsigned phase, count, span, pick, row, col;
    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      wait_idle();
      set_idling(idling_e'(phase % 4));
      if (phase % 5 == 4) begin
        case ($urandom_range(3))
          0:       count = 0;
          1:       count = 1;
          default: count = $urandom_range(8, 127);
        endcase
      end else begin
        count = $urandom_range(2, 7);
      end
      set_city_count(COUNT_W'(count));
      span = (count < 2) ? 2 : ((count > 7) ? 7 : count);
      for (int unsigned r = 0; r < span; r++) begin
        for (int unsigned c = 0; c < span; c++) begin
          send_road(r, c, pick_cost(),
                    (r != c) ? ($urandom_range(9) != 0) : $urandom_range(1));
        end
      end
      repeat (30) begin
        pick = $urandom_range(99);
        row  = ($urandom_range(9) != 0) ? $urandom_range(span - 1) : $urandom_range(63);
        col  = ($urandom_range(9) != 0) ? $urandom_range(span - 1) : $urandom_range(63);
        if (pick < 55) begin
          ask_extend(row, col, pick_parent());
        end else if (pick < 70) begin
          send_road(row, col, pick_cost(), $urandom_range(4) != 0);
        end else if (pick < 80) begin
          // keep whole-table walks rare: they walk count squared entries
          if (count <= 16) ask_initial();
          else ask_extend(row, col, pick_parent());
        end else if (pick < 90) begin
          send_road($urandom_range(63), $urandom_range(63), pick_cost(),
                    $urandom_range(1));
        end else begin
          send_spare_code();
        end
      end
      phase++;
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare every accepted result beat with the oldest
  // prediction; report the first few faults in full, count the rest
  // --------------------------------------------------------------------------
  task automatic note_fault(input string what, input result_t want, input result_t got);
    if (fault_count < REPORT_LIMIT) begin
      $display("%0t %s: expected bound=%0d inf=%0b cost=%h present=%0b",
               $realtime, what, $signed(want.bound), want.infinite, want.edge_cost,
               want.edge_present);
      $display("%0t %s: actual   bound=%0d inf=%0b cost=%h present=%0b",
               $realtime, what, $signed(got.bound), got.infinite, got.edge_cost,
               got.edge_present);
    end
    fault_count++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = {res_bound, res_infinite, res_edge_cost, res_edge_present};
      if (pending_q.size() == 0) begin
        note_fault("result beat with nothing pending", '0, got);
      end else begin
        want = pending_q.pop_front();
        if (got.bound !== want.bound || got.infinite !== want.infinite ||
            got.edge_cost !== want.edge_cost || got.edge_present !== want.edge_present)
          note_fault("result mismatch", want, got);
      end
    end
  end

  // Watchdog: abandon the run if it stalls or drags on far too long.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (road_tab[i]) road_tab[i] = '0;
    cities_cfg = COUNT_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // the first beat waits out the table sweep through in_stall
    test_after_reset();
    test_directed();
    test_count_extremes();
    test_full_table();
    test_output_hold();
    test_random_traffic();
    // let any stray result beat surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tlb_pkg.sv
hw/rtl/tlb_ram.sv
hw/rtl/tlb_two_min.sv
hw/rtl/tour_lower_bound_engine.sv
sim/testbench.sv
